FILE: rtl/core/tdpt_pkg.sv
// Types, constants and the control store for the trial-division prime tester.
// Used by trial_division_prime_test_top and tdpt_checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int SQ_WIDTH    = VALUE_WIDTH + 1;
    localparam int BIT_WIDTH   = $clog2(VALUE_WIDTH);
    localparam int UPC_WIDTH   = 3;

    typedef enum logic [1:0] {
        STATUS_COMPOSITE = 2'd0,
        STATUS_PRIME     = 2'd1,
        STATUS_INVALID   = 2'd2
    } t_status;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] candidate;
        logic                   range_last;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] tested_value;
        t_status                status;
        logic                   last;
    } t_out_item;

    // branch conditions tested by a control word
    typedef enum logic [2:0] {
        C_IN_VALID,
        C_N_ZERO,
        C_N_ONE,
        C_SQ_GT_N,
        C_BIT_LAST,
        C_REM_ZERO,
        C_OUT_FREE
    } t_cond;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SET_INVALID,
        OP_SET_COMP,
        OP_SET_PRIME,
        OP_INIT_DIV,
        OP_DIV_STEP,
        OP_NEXT_D,
        OP_EMIT
    } t_op;

    typedef logic [UPC_WIDTH-1:0] t_upc;

    typedef struct packed {
        logic  in_ready;
        t_cond cond;
        t_op   op_t;   // op when the condition holds
        t_op   op_f;   // op otherwise
        t_upc  jt;
        t_upc  jf;
    } t_uword;

    localparam t_upc UPC_WAIT = 3'd0;
    localparam t_upc UPC_ZERO = 3'd1;
    localparam t_upc UPC_ONE  = 3'd2;
    localparam t_upc UPC_TEST = 3'd3;
    localparam t_upc UPC_DIV  = 3'd4;
    localparam t_upc UPC_REM  = 3'd5;
    localparam t_upc UPC_OUT  = 3'd6;

    function automatic t_uword uprog(input t_upc pc);
        t_uword w;
        unique case (pc)
            UPC_WAIT: w = '{1'b1, C_IN_VALID, OP_LOAD,        OP_NONE,     UPC_ZERO, UPC_WAIT};
            UPC_ZERO: w = '{1'b0, C_N_ZERO,   OP_SET_INVALID, OP_NONE,     UPC_OUT,  UPC_ONE};
            UPC_ONE:  w = '{1'b0, C_N_ONE,    OP_SET_COMP,    OP_NONE,     UPC_OUT,  UPC_TEST};
            UPC_TEST: w = '{1'b0, C_SQ_GT_N,  OP_SET_PRIME,   OP_INIT_DIV, UPC_OUT,  UPC_DIV};
            UPC_DIV:  w = '{1'b0, C_BIT_LAST, OP_DIV_STEP,    OP_DIV_STEP, UPC_REM,  UPC_DIV};
            UPC_REM:  w = '{1'b0, C_REM_ZERO, OP_SET_COMP,    OP_NEXT_D,   UPC_OUT,  UPC_TEST};
            UPC_OUT:  w = '{1'b0, C_OUT_FREE, OP_EMIT,        OP_NONE,     UPC_WAIT, UPC_OUT};
            default:  w = '{1'b0, C_IN_VALID, OP_NONE,        OP_NONE,     UPC_WAIT, UPC_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/trial_division_prime_test_top.sv
// Divisors from 2 up to floor(sqrt(n)) are tried by trial division.
// Throughput: one item at a time; the bit-serial remainder unit works one quotient bit per
//   cycle. The result register frees the input side while it waits.
// Reset: synchronous, active low; clears the step counter and the result valid.
// Top level: microcoded trial-division prime tester. Depends on tdpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_test_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire tdpt_pkg::t_in_item  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output tdpt_pkg::t_out_item      o_out
);
    import tdpt_pkg::*;

    t_upc                   r_pc,     n_pc;
    logic [VALUE_WIDTH-1:0] r_n,      n_n;
    logic                   r_last,   n_last;
    logic [VALUE_WIDTH-1:0] r_d,      n_d;
    logic [SQ_WIDTH-1:0]    r_sq,     n_sq;     // r_d squared
    logic [VALUE_WIDTH-1:0] r_rem,    n_rem;
    logic [BIT_WIDTH-1:0]   r_bit,    n_bit;
    t_status                r_status, n_status;
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out,    n_out;

    t_uword                 w;
    logic                   cond_hit;
    t_op                    op;
    logic                   out_free;
    logic [VALUE_WIDTH:0]   shifted;
    logic                   ge;

    assign w        = uprog(r_pc);
    assign out_free = !r_out_valid || i_out_ready;
    assign shifted  = {r_rem, r_n[r_bit]};
    assign ge       = shifted >= {1'b0, r_d};

    always_comb begin
        unique case (w.cond)
            C_IN_VALID: cond_hit = i_in_valid;
            C_N_ZERO:   cond_hit = (r_n == '0);
            C_N_ONE:    cond_hit = (r_n == VALUE_WIDTH'(1));
            C_SQ_GT_N:  cond_hit = (r_sq > {1'b0, r_n});
            C_BIT_LAST: cond_hit = (r_bit == '0);
            C_REM_ZERO: cond_hit = (r_rem == '0);
            C_OUT_FREE: cond_hit = out_free;
            default:    cond_hit = 1'b0;
        endcase
    end

    assign op = cond_hit ? w.op_t : w.op_f;

    always_comb begin
        n_pc        = cond_hit ? w.jt : w.jf;
        n_n         = r_n;
        n_last      = r_last;
        n_d         = r_d;
        n_sq        = r_sq;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (op)
            OP_NONE: begin
            end
            OP_LOAD: begin
                n_n    = i_in.candidate;
                n_last = i_in.range_last;
                n_d    = VALUE_WIDTH'(2);
                n_sq   = SQ_WIDTH'(4);
            end
            OP_SET_INVALID: n_status = STATUS_INVALID;
            OP_SET_COMP:    n_status = STATUS_COMPOSITE;
            OP_SET_PRIME:   n_status = STATUS_PRIME;
            OP_INIT_DIV: begin
                n_rem = '0;
                n_bit = BIT_WIDTH'(VALUE_WIDTH - 1);
            end
            OP_DIV_STEP: begin
                // restoring step: shift in next dividend bit, subtract if it fits
                n_rem = ge ? VALUE_WIDTH'(shifted - {1'b0, r_d}) : shifted[VALUE_WIDTH-1:0];
                n_bit = r_bit - 1'b1;
            end
            OP_NEXT_D: begin
                // (d+1)^2 = d^2 + 2d + 1
                n_d  = r_d + 1'b1;
                n_sq = r_sq + {r_d, 1'b1};
            end
            OP_EMIT: begin
                n_out       = '{tested_value: r_n, status: r_status, last: r_last};
                n_out_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= UPC_WAIT;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
        r_n      <= n_n;
        r_last   <= n_last;
        r_d      <= n_d;
        r_sq     <= n_sq;
        r_rem    <= n_rem;
        r_bit    <= n_bit;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_in_ready  = w.in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

FILE: rtl/core/tdpt_checker.sv
// Port-level checks for trial_division_prime_test_top, bound to the top level.
// Depends on tdpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire tdpt_pkg::t_out_item o_out
);
    import tdpt_pkg::*;

    // a pending result transfer is never dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before transfer");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_zero_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.tested_value == '0 |-> o_out.status == STATUS_INVALID)
        else $error("zero not reported invalid");

    a_one_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.tested_value == VALUE_WIDTH'(1)
            |-> o_out.status == STATUS_COMPOSITE)
        else $error("one not reported composite");

    a_even_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.tested_value[0] && o_out.tested_value > VALUE_WIDTH'(2)
            |-> o_out.status == STATUS_COMPOSITE)
        else $error("even value above two not composite");

endmodule

bind trial_division_prime_test_top tdpt_checker u_tdpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

`default_nettype wire
